// ----- src/spi_clock_divisor_search_macros.svh -----
// Assertion helpers for the clock divisor search block.
`ifndef SPI_CLOCK_DIVISOR_SEARCH_MACROS_SVH
`define SPI_CLOCK_DIVISOR_SEARCH_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define SCDS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("scds assertion failed");

// Condition that must never be seen at a clock edge outside reset.
`define SCDS_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("scds forbidden condition seen");

`endif

// ----- src/scds_pkg.sv -----
package scds_pkg;

  localparam int unsigned PclkW   = 31;
  localparam int unsigned RateW   = 32;
  localparam int unsigned StepW   = 40;  // (rate+1)*prescale < 2^40
  localparam int unsigned AccW    = 48;  // step*(scr+1) < 2^48

  localparam logic [RateW-1:0] TargetReset = 32'd2000000;
  localparam logic [7:0] PrescaleMin  = 8'd2;
  localparam logic [7:0] PrescaleMax  = 8'd254;
  localparam logic [7:0] ScrMax       = 8'd255;
  localparam logic [7:0] DefPrescale  = 8'd2;
  localparam logic [7:0] DefScr       = 8'd39;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SEARCH
  } state_e;

endpackage

// ----- src/spi_clock_divisor_search.sv -----
// One candidate compare per cycle through a single shared 48-bit adder; a found result
// waits in the search unit until the output register is free.
// Throughput: one item at a time; input ready only while the search unit is idle.
// A finished result is held in an output register until taken; a new item may be
// accepted while it waits. Reset: asynchronous active low, target_rate = 2000000.
module spi_clock_divisor_search (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [30:0] pclk_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  prescale_o,
  output logic [7:0]  scr_o,
  output logic        used_default_o
);

  scds_pkg::state_e state_q, state_d;

  logic [scds_pkg::RateW-1:0] target_q;
  logic [scds_pkg::PclkW-1:0] pclk_q, pclk_d;
  logic [7:0]                 ps_q, ps_d;
  logic [7:0]                 scr_q, scr_d;
  logic [scds_pkg::StepW-1:0] step_q, step_d;
  logic [scds_pkg::AccW-1:0]  acc_q, acc_d;

  logic       out_valid_q, out_valid_d;
  logic [7:0] out_ps_q, out_ps_d;
  logic [7:0] out_scr_q, out_scr_d;
  logic       out_def_q, out_def_d;

  logic [scds_pkg::RateW:0]   rate_p1;
  logic [scds_pkg::StepW-1:0] rate_x2;
  logic [scds_pkg::AccW-1:0]  add_a, add_b, add_sum;
  logic                       hit, last_scr, last_ps, out_free, in_fire;

  assign rate_p1  = {1'b0, target_q} + {{scds_pkg::RateW{1'b0}}, 1'b1};
  assign rate_x2  = {{(scds_pkg::StepW-scds_pkg::RateW-2){1'b0}}, rate_p1, 1'b0};
  assign hit      = {{(scds_pkg::AccW-scds_pkg::PclkW){1'b0}}, pclk_q} < acc_q;
  assign last_scr = (scr_q == scds_pkg::ScrMax);
  assign last_ps  = (ps_q == scds_pkg::PrescaleMax);
  assign out_free = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == scds_pkg::ST_IDLE);
  assign in_fire  = in_valid_i && in_ready_o;

  // shared adder: next scr adds step to acc, next prescale adds 2*(rate+1) to step
  always_comb begin
    if (last_scr) begin
      add_a = {{(scds_pkg::AccW-scds_pkg::StepW){1'b0}}, step_q};
      add_b = {{(scds_pkg::AccW-scds_pkg::StepW){1'b0}}, rate_x2};
    end else begin
      add_a = acc_q;
      add_b = {{(scds_pkg::AccW-scds_pkg::StepW){1'b0}}, step_q};
    end
  end
  assign add_sum = add_a + add_b;

  always_comb begin
    state_d     = state_q;
    pclk_d      = pclk_q;
    ps_d        = ps_q;
    scr_d       = scr_q;
    step_d      = step_q;
    acc_d       = acc_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_ps_d    = out_ps_q;
    out_scr_d   = out_scr_q;
    out_def_d   = out_def_q;

    unique case (state_q)
      scds_pkg::ST_IDLE: begin
        if (in_fire) begin
          pclk_d  = pclk_i;
          ps_d    = scds_pkg::PrescaleMin;
          scr_d   = 8'd0;
          step_d  = rate_x2;
          acc_d   = {{(scds_pkg::AccW-scds_pkg::StepW){1'b0}}, rate_x2};
          state_d = scds_pkg::ST_SEARCH;
        end
      end
      scds_pkg::ST_SEARCH: begin
        if (hit || (last_ps && last_scr)) begin
          // hold the candidate until the output register frees up
          if (out_free) begin
            out_valid_d = 1'b1;
            out_ps_d    = hit ? ps_q  : scds_pkg::DefPrescale;
            out_scr_d   = hit ? scr_q : scds_pkg::DefScr;
            out_def_d   = !hit;
            state_d     = scds_pkg::ST_IDLE;
          end
        end else if (last_scr) begin
          ps_d   = ps_q + 8'd2;
          scr_d  = 8'd0;
          step_d = add_sum[scds_pkg::StepW-1:0];
          acc_d  = add_sum;
        end else begin
          scr_d = scr_q + 8'd1;
          acc_d = add_sum;
        end
      end
      default: state_d = scds_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scds_pkg::ST_IDLE;
      target_q    <= scds_pkg::TargetReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        target_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pclk_q    <= pclk_d;
    ps_q      <= ps_d;
    scr_q     <= scr_d;
    step_q    <= step_d;
    acc_q     <= acc_d;
    out_ps_q  <= out_ps_d;
    out_scr_q <= out_scr_d;
    out_def_q <= out_def_d;
  end

  assign out_valid_o    = out_valid_q;
  assign prescale_o     = out_ps_q;
  assign scr_o          = out_scr_q;
  assign used_default_o = out_def_q;

endmodule

// ----- src/scds_checker.sv -----
`include "spi_clock_divisor_search_macros.svh"

module scds_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  prescale_o,
  input logic [7:0]  scr_o,
  input logic        used_default_o
);

  logic [16:0] out_bits;

  assign out_bits = {prescale_o, scr_o, used_default_o};

  // a stalled result beat holds
  `SCDS_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_bits))

  // prescale is always even and in range
  `SCDS_ASSERT_NEVER(a_ps_odd, out_valid_o && (prescale_o[0] || prescale_o == 8'd0))

  // fallback pair
  `SCDS_ASSERT(a_default, out_valid_o && used_default_o |-> prescale_o == scds_pkg::DefPrescale && scr_o == scds_pkg::DefScr)

  // not ready in the cycle after taking an item
  `SCDS_ASSERT(a_busy, in_valid_i && in_ready_o |=> !in_ready_o)

endmodule

bind spi_clock_divisor_search scds_checker u_scds_checker (.*);

// ----- tb/spi_clock_divisor_search_tb.sv -----
`timescale 1ns / 1ps

module spi_clock_divisor_search_tb;

  localparam int unsigned CycleLimit = 12000000;
  localparam int unsigned HoldCycles = 3000;
  localparam logic [63:0] PclkTop = 64'h7FFF_FFFF;

  typedef struct packed {
    logic [7:0] prescale;
    logic [7:0] scr;
    logic       used_default;
  } divisor_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [scds_pkg::RateW-1:0] cfg_data_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic [scds_pkg::PclkW-1:0] pclk_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  logic [7:0]                 prescale_o;
  logic [7:0]                 scr_o;
  logic                       used_default_o;

  logic [scds_pkg::RateW-1:0] rate_model = scds_pkg::TargetReset;
  divisor_t         divisor_q[$];
  divisor_t         want_div;
  int unsigned      idle_pct = 20;
  logic             sink_blocked = 1'b0;
  int unsigned      err_cnt = 0;
  int unsigned      beat_cnt = 0;
  int unsigned      default_cnt = 0;
  int unsigned      setting_cnt = 1;
  int unsigned      deep_left = 4;
  int unsigned      cycle_cnt = 0;
  event             hold_ev;

  spi_clock_divisor_search dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pclk_i         (pclk_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .prescale_o     (prescale_o),
    .scr_o          (scr_o),
    .used_default_o (used_default_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // First even prescale, then smallest scr, with pclk < (rate+1)*prescale*(scr+1).
  function automatic divisor_t search_divisor(logic [scds_pkg::PclkW-1:0] pclk,
                                              logic [scds_pkg::RateW-1:0] rate);
    divisor_t    r;
    logic [63:0] step;
    logic [63:0] q;
    r = '{prescale: scds_pkg::DefPrescale, scr: scds_pkg::DefScr, used_default: 1'b1};
    for (int ps = int'(scds_pkg::PrescaleMin);
         ps <= int'(scds_pkg::PrescaleMax) && r.used_default; ps += 2) begin
      step = ({32'd0, rate} + 64'd1) * 64'(ps);
      q = {33'd0, pclk} / step;
      if (q <= 64'(scds_pkg::ScrMax)) begin
        r.prescale = 8'(ps);
        r.scr = q[7:0];
        r.used_default = 1'b0;
      end
    end
    return r;
  endfunction

  // Random pclk that resolves at the given prescale under the current rate; when that band
  // lies above the field range, any value resolves earlier.
  function automatic logic [scds_pkg::PclkW-1:0] pclk_near_prescale(int ps);
    logic [63:0] unit;
    logic [63:0] lo;
    logic [63:0] hi;
    unit = ({32'd0, rate_model} + 64'd1) * 64'd256;
    lo = unit * 64'(ps - 2);
    hi = unit * 64'(ps) - 64'd1;
    if (hi > PclkTop) hi = PclkTop;
    if (lo > hi) lo = 64'd0;
    return (scds_pkg::PclkW)'(lo + ({32'd0, $urandom()} % (hi - lo + 64'd1)));
  endfunction

  // Mostly shallow searches; a handful of unconstrained values may run the full sweep.
  function automatic logic [scds_pkg::PclkW-1:0] random_pclk();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return pclk_near_prescale(2);
    if (roll < 90) return pclk_near_prescale(2 * $urandom_range(4, 2));
    if (roll < 97) return pclk_near_prescale(2 * $urandom_range(20, 5));
    if (deep_left != 0) begin
      deep_left--;
      return (scds_pkg::PclkW)'($urandom());
    end
    return pclk_near_prescale(2);
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    $display("[%0t] MISMATCH: %s", $time, msg);
  endtask

  // Returns just after the accepting edge; valid stays up until the next call or a drain.
  task automatic send_pclk(input logic [scds_pkg::PclkW-1:0] pclk);
    divisor_t d;
    @(negedge clk_i);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(negedge clk_i); while ($urandom_range(99) < 50);
    end
    in_valid_i <= 1'b1;
    pclk_i <= pclk;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    d = search_divisor(pclk, rate_model);
    divisor_q.push_back(d);
    beat_cnt++;
    if (d.used_default) default_cnt++;
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (divisor_q.size() != 0) @(posedge clk_i);
  endtask

  // Only called with nothing in flight.
  task automatic write_target(input logic [scds_pkg::RateW-1:0] rate);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= rate;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    rate_model = rate;
    setting_cnt++;
  endtask

  always @(negedge clk_i) begin
    if (sink_blocked) out_ready_i <= 1'b0;
    else out_ready_i <= (idle_pct == 0) || ($urandom_range(99) >= idle_pct);
  end

  initial forever begin
    @(hold_ev);
    @(posedge clk_i);
    sink_blocked = 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    sink_blocked = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (divisor_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want_div = divisor_q.pop_front();
        if (prescale_o !== want_div.prescale)
          report_mismatch($sformatf("prescale %0d, want %0d", prescale_o, want_div.prescale));
        if (scr_o !== want_div.scr)
          report_mismatch($sformatf("scr %0d, want %0d", scr_o, want_div.scr));
        if (used_default_o !== want_div.used_default)
          report_mismatch($sformatf("used_default %b, want %b", used_default_o,
                                    want_div.used_default));
      end
    end
  end

  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, divisor_q.size());
    $display("spi_clock_divisor_search regression: fail");
    $finish;
  end

  // Reset rate 2000000: scr and prescale boundaries, both field extremes.
  task automatic test_reset_rate();
    send_pclk('0);
    send_pclk(31'd1);
    send_pclk(31'd4000001);
    send_pclk(31'd4000002);
    send_pclk(31'd1024000511);
    send_pclk(31'd1024000512);
    send_pclk(31'h7FFF_FFFF);
    drain_results();
  endtask

  // Zero rate reaches the last pair and the default; all-ones rate always takes 2,0.
  task automatic test_rate_extremes();
    write_target('0);
    send_pclk('0);
    send_pclk(31'd1);
    send_pclk(31'd2);
    send_pclk(31'd511);
    send_pclk(31'd512);
    send_pclk(31'd65023);
    send_pclk(31'd65024);
    send_pclk(31'h7FFF_FFFF);
    drain_results();
    write_target('1);
    send_pclk(31'h7FFF_FFFF);
    send_pclk('0);
    send_pclk(31'h5555_5555);
    drain_results();
  endtask

  // Sink stalls long enough that the result register and the search unit both fill.
  task automatic test_output_holdoff();
    write_target($urandom_range(200000, 1000));
    -> hold_ev;
    repeat (6) send_pclk(pclk_near_prescale(2));
    drain_results();
  endtask

  task automatic test_pause_until_empty();
    repeat (5) send_pclk(random_pclk());
    drain_results();
    repeat (5) send_pclk(random_pclk());
    drain_results();
  endtask

  task automatic test_random_rates();
    logic [scds_pkg::RateW-1:0] rate;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: rate = $urandom();
        1: rate = $urandom_range(1000);
        2: rate = $urandom_range(5000000, 100000);
        3: rate = scds_pkg::TargetReset;
        default: rate = $urandom_range(64);
      endcase
      write_target(rate);
      idle_pct = (ph == 2) ? 0 : 20;
      repeat (15) send_pclk(random_pclk());
      drain_results();
    end
    idle_pct = 20;
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_rate();
    test_rate_extremes();
    test_output_holdoff();
    test_pause_until_empty();
    test_random_rates();
    repeat (40) @(posedge clk_i);
    $display("%0d pclk beats over %0d rate settings (zero, all-ones, reset, random),",
             beat_cnt, setting_cnt);
    $display("%0d fell back to the default pair; %0d cycles", default_cnt, cycle_cnt);
    if (err_cnt == 0) begin
      $display("spi_clock_divisor_search regression: pass");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("spi_clock_divisor_search regression: fail");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/scds_pkg.sv
src/spi_clock_divisor_search.sv
src/scds_checker.sv
tb/spi_clock_divisor_search_tb.sv
